>>> design/fixed_huffman_inflate_macros.svh
// Assertion helpers for the inflate block; each expects clk and arst_n in scope.
`ifndef FIXED_HUFFMAN_INFLATE_MACROS_SVH
`define FIXED_HUFFMAN_INFLATE_MACROS_SVH

// Same-cycle implication.
`define FHI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FHI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/fhi_pkg.sv
package fhi_pkg;

	localparam int SIZE_BITS  = 24;
	localparam int WIN_BYTES  = 32768;
	localparam int WIN_AW     = $clog2(WIN_BYTES);

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DATA = 2'd1;
	localparam logic [1:0] ST_BUF  = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SYMBOL,
		PH_LEN_EXTRA,
		PH_DIST_CODE,
		PH_DIST_EXTRA,
		PH_PAD
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_BIT,
		C_COPY_RD,
		C_COPY_WR,
		C_FLUSH,
		C_STATUS
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic skip;
		logic step;
		logic copy_rd;
		logic copy_wr;
		logic push_pack;
		logic push_status;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic fault_seen;
		logic pack_full;
		logic pack_empty;
		logic bits_one;
		logic bits_zero;
		logic step_copy;
		logic step_fault;
		logic mlen_one;
		logic end_valid;
		logic out_free;
	} st_t;

	function automatic logic [3:0] len_extra(input logic [4:0] idx);
		logic [4:0] t;
		begin
			t = idx - 5'd8;
			if (idx < 5'd8 || idx == 5'd28) return 4'd0;
			return {1'b0, t[4:2]} + 4'd1;
		end
	endfunction

	function automatic logic [8:0] len_base(input logic [4:0] idx);
		logic [4:0] t;
		logic [3:0] ex;
		begin
			t  = idx - 5'd8;
			ex = len_extra(idx);
			if (idx < 5'd8) return {4'd0, idx} + 9'd3;
			if (idx == 5'd28) return 9'd258;
			return 9'd3 + (9'd1 << (ex + 4'd2)) + ({7'd0, t[1:0]} << ex);
		end
	endfunction

	function automatic logic [3:0] dist_extra(input logic [4:0] code);
		begin
			if (code < 5'd4) return 4'd0;
			return code[4:1] - 4'd1;
		end
	endfunction

	function automatic logic [15:0] dist_base(input logic [4:0] code);
		logic [3:0] ex;
		begin
			ex = dist_extra(code);
			if (code < 5'd4) return {11'd0, code} + 16'd1;
			return 16'd1 + (16'd1 << (ex + 4'd1)) + ({15'd0, code[0]} << ex);
		end
	endfunction

endpackage

>>> design/fhi_if.sv
interface fhi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;
	modport source (output valid, in_byte, last_byte, input ready);
	modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface fhi_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  out_count;
	logic        stream_done;
	logic [1:0]  status;
	modport source (output valid, out_bytes, out_count, stream_done, status, input ready);
	modport sink (input valid, out_bytes, out_count, stream_done, status, output ready);
endinterface

>>> design/fhi_datapath.sv
module fhi_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fhi_pkg::cmd_t                   cmd,
	output fhi_pkg::st_t                    st,
	input  logic [7:0]                      in_byte,
	input  logic                            last_byte,
	input  logic [fhi_pkg::SIZE_BITS-1:0]   output_length,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [63:0]                     out_bytes,
	output logic [3:0]                      out_count,
	output logic                            stream_done,
	output logic [1:0]                      status
);

	localparam int SB = fhi_pkg::SIZE_BITS;
	localparam int AW = fhi_pkg::WIN_AW;

	logic [7:0]       sh_q;
	logic [3:0]       bits_q;
	logic             last_q;
	fhi_pkg::phase_t  phase_q;
	logic [8:0]       code_q;
	logic [3:0]       cbr_q;
	logic [8:0]       mlen_q;
	logic [15:0]      dist_q;
	logic [3:0]       extra_q;
	logic [SB-1:0]    produced_q;
	logic             fault_q;
	logic             fault_byte_q;
	logic [1:0]       fcode_q;
	logic [63:0]      pack_q;
	logic [3:0]       pack_n_q;
	logic [7:0]       rdata_q;
	logic             ovalid_q;
	logic [63:0]      obytes_q;
	logic [3:0]       ocount_q;
	logic             odone_q;
	logic [1:0]       ostat_q;

	logic [7:0] hist_mem [fhi_pkg::WIN_BYTES];

	// bit step outcome
	fhi_pkg::phase_t  nx_phase;
	logic [8:0]       nx_code;
	logic [3:0]       nx_cbr;
	logic [8:0]       nx_mlen;
	logic [15:0]      nx_dist;
	logic [3:0]       nx_extra;
	logic             step_emit;
	logic [7:0]       step_byte;
	logic             step_copy;
	logic             step_fault;
	logic [1:0]       step_fcode;

	logic             bit_v;
	logic [3:0]       cnt_n;
	logic [8:0]       hc;
	logic [8:0]       sc;
	logic [4:0]       dc5;
	logic [8:0]       sym;
	logic [8:0]       sidx;
	logic             hs;
	logic             hd;
	logic             dcopy;

	logic             emit;
	logic [7:0]       ebyte;
	logic             end_valid;
	logic [1:0]       end_code;
	logic             out_free;

	always_comb begin
		nx_phase   = phase_q;
		nx_code    = code_q;
		nx_cbr     = cbr_q;
		nx_mlen    = mlen_q;
		nx_dist    = dist_q;
		nx_extra   = extra_q;
		step_emit  = 1'b0;
		step_byte  = 8'd0;
		step_copy  = 1'b0;
		step_fault = 1'b0;
		step_fcode = fhi_pkg::ST_DATA;
		bit_v      = sh_q[0];
		cnt_n      = cbr_q + 4'd1;
		hc         = code_q | ({8'd0, bit_v} << cbr_q);
		sc         = {code_q[7:0], bit_v};
		dc5        = {code_q[3:0], bit_v};
		sym        = 9'd0;
		sidx       = 9'd0;
		hs         = 1'b0;
		hd         = 1'b0;
		dcopy      = 1'b0;
		case (phase_q)
			fhi_pkg::PH_HEADER: begin
				nx_code = hc;
				nx_cbr  = cnt_n;
				if (cnt_n == 4'd3) begin
					if (hc != 9'd3) begin
						step_fault = 1'b1;
					end else begin
						nx_phase = fhi_pkg::PH_SYMBOL;
						nx_code  = 9'd0;
						nx_cbr   = 4'd0;
					end
				end
			end
			fhi_pkg::PH_SYMBOL: begin
				nx_code = sc;
				nx_cbr  = cnt_n;
				if (cnt_n == 4'd7 && sc < 9'd24) begin
					hs  = 1'b1;
					sym = 9'd256 + sc;
				end else if (cnt_n == 4'd8 && sc >= 9'd48 && sc < 9'd192) begin
					hs  = 1'b1;
					sym = sc - 9'd48;
				end else if (cnt_n == 4'd8 && sc >= 9'd192 && sc < 9'd200) begin
					hs  = 1'b1;
					sym = sc + 9'd88;
				end else if (cnt_n >= 4'd9) begin
					if (sc >= 9'd400) begin
						hs  = 1'b1;
						sym = sc - 9'd256;
					end else begin
						step_fault = 1'b1;
					end
				end
			end
			fhi_pkg::PH_LEN_EXTRA: begin
				nx_mlen = mlen_q + ({8'd0, bit_v} << cbr_q);
				nx_cbr  = cnt_n;
				if (cnt_n >= extra_q) begin
					nx_phase = fhi_pkg::PH_DIST_CODE;
					nx_code  = 9'd0;
					nx_cbr   = 4'd0;
				end
			end
			fhi_pkg::PH_DIST_CODE: begin
				nx_code = {4'd0, dc5};
				nx_cbr  = cnt_n;
				if (cnt_n == 4'd5) hd = 1'b1;
			end
			fhi_pkg::PH_DIST_EXTRA: begin
				nx_dist = dist_q + ({15'd0, bit_v} << cbr_q);
				nx_cbr  = cnt_n;
				if (cnt_n >= extra_q) dcopy = 1'b1;
			end
			fhi_pkg::PH_PAD: begin
				if (bit_v) step_fault = 1'b1;
			end
			default: step_fault = 1'b1;
		endcase

		if (hs) begin
			nx_code = 9'd0;
			nx_cbr  = 4'd0;
			sidx    = sym - 9'd257;
			if (sym < 9'd256) begin
				if (produced_q >= output_length) begin
					step_fault = 1'b1;
					step_fcode = fhi_pkg::ST_BUF;
				end else begin
					step_emit = 1'b1;
					step_byte = sym[7:0];
				end
			end else if (sym == 9'd256) begin
				nx_phase = fhi_pkg::PH_PAD;
			end else if (sym > 9'd285) begin
				step_fault = 1'b1;
			end else begin
				nx_mlen  = fhi_pkg::len_base(sidx[4:0]);
				nx_extra = fhi_pkg::len_extra(sidx[4:0]);
				nx_phase = (nx_extra != 4'd0) ? fhi_pkg::PH_LEN_EXTRA : fhi_pkg::PH_DIST_CODE;
			end
		end

		if (hd) begin
			nx_code = 9'd0;
			nx_cbr  = 4'd0;
			if (dc5 > 5'd29) begin
				step_fault = 1'b1;
			end else begin
				nx_dist  = fhi_pkg::dist_base(dc5);
				nx_extra = fhi_pkg::dist_extra(dc5);
				if (nx_extra == 4'd0) dcopy = 1'b1;
				else nx_phase = fhi_pkg::PH_DIST_EXTRA;
			end
		end

		if (dcopy) begin
			if ({{(SB-16){1'b0}}, nx_dist} > produced_q || produced_q > output_length ||
			    {{(SB-9){1'b0}}, mlen_q} > output_length - produced_q) begin
				step_fault = 1'b1;
			end else begin
				step_copy = 1'b1;
				nx_phase  = fhi_pkg::PH_SYMBOL;
				nx_code   = 9'd0;
				nx_cbr    = 4'd0;
			end
		end
	end

	assign emit  = (cmd.step && step_emit) || cmd.copy_wr;
	assign ebyte = cmd.copy_wr ? rdata_q : step_byte;

	always_comb begin
		end_valid = 1'b0;
		end_code  = fhi_pkg::ST_DATA;
		if (fault_byte_q) begin
			end_valid = 1'b1;
			end_code  = fcode_q;
		end else if (phase_q == fhi_pkg::PH_PAD) begin
			end_valid = 1'b1;
			if (last_q && produced_q == output_length) end_code = fhi_pkg::ST_OK;
		end else if (last_q) begin
			end_valid = 1'b1;
		end
	end

	assign out_free = !ovalid_q || out_ready;

	always_comb begin
		st            = '0;
		st.fault_seen = fault_q;
		st.pack_full  = pack_n_q[3];
		st.pack_empty = (pack_n_q == 4'd0);
		st.bits_one   = (bits_q == 4'd1);
		st.bits_zero  = (bits_q == 4'd0);
		st.step_copy  = step_copy;
		st.step_fault = step_fault;
		st.mlen_one   = (mlen_q == 9'd1);
		st.end_valid  = end_valid;
		st.out_free   = out_free;
	end

	// history window: written with every emitted byte, read for copies
	always_ff @(posedge clk) begin
		if (emit) hist_mem[produced_q[AW-1:0]] <= ebyte;
		if (cmd.copy_rd) rdata_q <= hist_mem[produced_q[AW-1:0] - dist_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q       <= 4'd0;
			last_q       <= 1'b0;
			phase_q      <= fhi_pkg::PH_HEADER;
			code_q       <= 9'd0;
			cbr_q        <= 4'd0;
			mlen_q       <= 9'd0;
			dist_q       <= 16'd0;
			extra_q      <= 4'd0;
			produced_q   <= '0;
			fault_q      <= 1'b0;
			fault_byte_q <= 1'b0;
			fcode_q      <= fhi_pkg::ST_OK;
			pack_q       <= 64'd0;
			pack_n_q     <= 4'd0;
			ovalid_q     <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (cmd.load) begin
				bits_q <= 4'd8;
				last_q <= last_byte;
			end
			if (cmd.skip && last_byte) begin
				phase_q    <= fhi_pkg::PH_HEADER;
				code_q     <= 9'd0;
				cbr_q      <= 4'd0;
				mlen_q     <= 9'd0;
				dist_q     <= 16'd0;
				extra_q    <= 4'd0;
				produced_q <= '0;
				fault_q    <= 1'b0;
			end
			if (cmd.step) begin
				bits_q  <= bits_q - 4'd1;
				phase_q <= nx_phase;
				code_q  <= nx_code;
				cbr_q   <= nx_cbr;
				mlen_q  <= nx_mlen;
				dist_q  <= nx_dist;
				extra_q <= nx_extra;
				if (step_fault) begin
					fault_q      <= 1'b1;
					fault_byte_q <= 1'b1;
					fcode_q      <= step_fcode;
				end
			end
			if (cmd.copy_wr) mlen_q <= mlen_q - 9'd1;
			if (emit) begin
				produced_q <= produced_q + SB'(1);
				pack_q     <= pack_q | ({56'd0, ebyte} << {pack_n_q[2:0], 3'd0});
				pack_n_q   <= pack_n_q + 4'd1;
			end
			if (cmd.push_pack) begin
				ovalid_q <= 1'b1;
				pack_q   <= 64'd0;
				pack_n_q <= 4'd0;
			end
			if (cmd.push_status) ovalid_q <= 1'b1;
			if (cmd.finish) begin
				fault_byte_q <= 1'b0;
				if (end_valid && end_code != fhi_pkg::ST_OK) fault_q <= 1'b1;
				if (last_q) begin
					phase_q    <= fhi_pkg::PH_HEADER;
					code_q     <= 9'd0;
					cbr_q      <= 4'd0;
					mlen_q     <= 9'd0;
					dist_q     <= 16'd0;
					extra_q    <= 4'd0;
					produced_q <= '0;
					fault_q    <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sh_q <= in_byte;
		else if (cmd.step) sh_q <= {1'b0, sh_q[7:1]};
		if (cmd.push_pack) begin
			obytes_q <= pack_q;
			ocount_q <= pack_n_q;
			odone_q  <= 1'b0;
			ostat_q  <= fhi_pkg::ST_OK;
		end else if (cmd.push_status) begin
			obytes_q <= 64'd0;
			ocount_q <= 4'd0;
			odone_q  <= 1'b1;
			ostat_q  <= end_code;
		end
	end

	assign out_valid   = ovalid_q;
	assign out_bytes   = obytes_q;
	assign out_count   = ocount_q;
	assign stream_done = odone_q;
	assign status      = ostat_q;

endmodule

>>> design/fhi_ctrl.sv
`include "fixed_huffman_inflate_macros.svh"

module fhi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fhi_pkg::st_t       st,
	output fhi_pkg::cmd_t      cmd
);

	fhi_pkg::ctl_state_t state_q;
	fhi_pkg::ctl_state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fhi_pkg::C_IDLE: begin
				if (in_valid && !st.fault_seen) state_d = fhi_pkg::C_BIT;
			end
			fhi_pkg::C_BIT: begin
				if (!st.pack_full) begin
					if (st.step_copy) state_d = fhi_pkg::C_COPY_RD;
					else if (st.step_fault || st.bits_one) state_d = fhi_pkg::C_FLUSH;
				end
			end
			fhi_pkg::C_COPY_RD: state_d = fhi_pkg::C_COPY_WR;
			fhi_pkg::C_COPY_WR: begin
				if (!st.pack_full) begin
					if (!st.mlen_one) state_d = fhi_pkg::C_COPY_RD;
					else if (st.bits_zero) state_d = fhi_pkg::C_FLUSH;
					else state_d = fhi_pkg::C_BIT;
				end
			end
			fhi_pkg::C_FLUSH: begin
				if (st.pack_empty || st.out_free) state_d = fhi_pkg::C_STATUS;
			end
			fhi_pkg::C_STATUS: begin
				if (!st.end_valid || st.out_free) state_d = fhi_pkg::C_IDLE;
			end
			default: state_d = fhi_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			fhi_pkg::C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = !st.fault_seen;
					cmd.skip = st.fault_seen;
				end
			end
			fhi_pkg::C_BIT: begin
				if (st.pack_full) cmd.push_pack = st.out_free;
				else cmd.step = 1'b1;
			end
			fhi_pkg::C_COPY_RD: cmd.copy_rd = 1'b1;
			fhi_pkg::C_COPY_WR: begin
				if (st.pack_full) cmd.push_pack = st.out_free;
				else cmd.copy_wr = 1'b1;
			end
			fhi_pkg::C_FLUSH: cmd.push_pack = !st.pack_empty && st.out_free;
			fhi_pkg::C_STATUS: begin
				cmd.push_status = st.end_valid && st.out_free;
				cmd.finish      = !st.end_valid || st.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhi_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FHI_ASSERT_NOW(a_wr_after_rd, state_q == fhi_pkg::C_COPY_WR,
		$past(state_q) == fhi_pkg::C_COPY_RD || $past(state_q) == fhi_pkg::C_COPY_WR,
		"copy write without a preceding read")
	`FHI_ASSERT_NEXT(a_load_starts, cmd.load, state_q == fhi_pkg::C_BIT,
		"loaded byte did not start bit decode")
	`FHI_ASSERT_NOW(a_push_free, cmd.push_pack || cmd.push_status, st.out_free,
		"result pushed into an occupied output register")
	`FHI_ASSERT_NOW(a_no_emit_full, cmd.step || cmd.copy_wr, !st.pack_full,
		"byte emitted into a full pack")

endmodule

>>> design/fixed_huffman_inflate.sv
// Channel   Dir  Payload                                        Handshake
// in_ch     in   in_byte[7:0], last_byte                        valid/ready
// out_ch    out  out_bytes[63:0], out_count, stream_done, status valid/ready
// apb       in   paddr[2:0], pwdata[31:0] -> output_length      psel/penable, pready=1
//
// An input byte is loaded, then decoded one bit per cycle except while the pack is full
// or a copy runs (eight bits, fewer once a fault stops the byte); each byte of a
// back-reference copy is a history read, then a write. Full packs are pushed mid-byte;
// a flush and a status step close the byte.
// Reset clears all control and stream state; the history memory is not cleared.
// A full output register stalls decode in place; no request is taken mid-byte.
module fixed_huffman_inflate (
	input  logic              clk,
	input  logic              arst_n,
	fhi_in_if.sink            in_ch,
	fhi_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SB = fhi_pkg::SIZE_BITS;

	fhi_pkg::cmd_t  cmd;
	fhi_pkg::st_t   st;
	logic [SB-1:0]  out_len_q;

	// Configuration: one register at byte addresses 0 to 3; writes land on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q <= {{(SB-1){1'b0}}, 1'b1};
		end else if (psel && penable && pwrite && !paddr[2]) begin
			out_len_q <= pwdata[SB-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-SB){1'b0}}, out_len_q};

	// Sequencer: takes a request, walks its bits, runs copies, flushes, reports.
	fhi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Decoder state, history window, byte packer and output register.
	fhi_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_byte       (in_ch.in_byte),
		.last_byte     (in_ch.last_byte),
		.output_length (out_len_q),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.out_bytes     (out_ch.out_bytes),
		.out_count     (out_ch.out_count),
		.stream_done   (out_ch.stream_done),
		.status        (out_ch.status)
	);

endmodule
